FILE: src/scr_pkg.sv
// Shared widths, constants and handshake types for the sphere collision resolver.
package scr_pkg;

  localparam int MAX_SPHERES = 16;
  localparam int IDX_W = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
  localparam int CNT_W = $clog2(MAX_SPHERES + 1);

  localparam int POS_W = 24;
  localparam int RAD_W = 20;
  localparam int GAP_W = 12;
  localparam int MD_W = RAD_W + 2;
  localparam int MAG_W = POS_W + 1;
  localparam int PROD_W = 2 * MAG_W;
  localparam int ROOT_W = PROD_W / 2;
  localparam int NUM_W = MAG_W + MD_W + 1;
  localparam int Q_W = MD_W + 2;
  localparam int DEN_W = ROOT_W;

  localparam logic [RAD_W-1:0] PLAYER_RADIUS_RST = RAD_W'(4014);
  localparam logic [GAP_W-1:0] DETECT_GAP_RST = GAP_W'(4);

  localparam logic CFG_PLAYER_RADIUS = 1'b0;
  localparam logic CFG_DETECT_GAP = 1'b1;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

FILE: src/scr_div.sv
// Bit-serial restoring divider producing a bounded quotient, one bit per cycle.
module scr_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  scr_pkg::div_ctl_t         ctl,
  input  logic [scr_pkg::NUM_W-1:0] num,
  input  logic [scr_pkg::DEN_W-1:0] den,
  output scr_pkg::div_sts_t         sts,
  output logic [scr_pkg::Q_W-1:0]   quot
);
  import scr_pkg::*;

  localparam int IT_W = $clog2(Q_W + 1);

  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [Q_W-1:0]   lo_r;
  logic [Q_W-1:0]   q_r;
  logic [IT_W-1:0]  it_r;
  logic             busy_r, done_r;
  logic [DEN_W:0]   trial;
  logic             ge;

  assign trial = {rem_r, lo_r[Q_W-1]};
  assign ge = (trial >= {1'b0, den});
  assign rem_nxt = ge ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      it_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        it_r <= IT_W'(Q_W);
      end else if (busy_r) begin
        it_r <= it_r - IT_W'(1);
        if (it_r == IT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem_r <= DEN_W'(num >> Q_W);
      lo_r <= num[Q_W-1:0];
      q_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      lo_r <= {lo_r[Q_W-2:0], 1'b0};
      q_r <= {q_r[Q_W-2:0], ge};
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quot = q_r;

endmodule

FILE: src/sphere_collision_resolve_core.sv
// Top level: sphere table, detection pass and push-out pass around one shared multiplier.
//
//   channel | direction | ports
//   in      | input     | in_valid, in_ready, in_cmd, in_pos_*, in_sphere_radius, in_info_present
//   out     | output    | out_valid, out_ready, out_collided, out_hit_*, out_x/y/z, out_table_full
//   cfg     | input     | cfg_valid, cfg_ready, cfg_index, cfg_data
//
// An add item goes from idle straight to the result state. A query walks entry, multiply and
// compare states for each entry in either pass; each pushed entry also takes 25 square root
// steps, then for each axis a product step, a divider start and a wait on the 24-step divider.
// Reset clears the entry count and loads the register defaults. A stalled result waits in the
// output register.
module sphere_collision_resolve_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_cmd,
  input  logic signed [scr_pkg::POS_W-1:0]  in_pos_x,
  input  logic signed [scr_pkg::POS_W-1:0]  in_pos_y,
  input  logic signed [scr_pkg::POS_W-1:0]  in_pos_z,
  input  logic [scr_pkg::RAD_W-1:0]         in_sphere_radius,
  input  logic                              in_info_present,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_collided,
  output logic [3:0]                        out_hit_index,
  output logic                              out_hit_info,
  output logic signed [scr_pkg::POS_W-1:0]  out_x,
  output logic signed [scr_pkg::POS_W-1:0]  out_y,
  output logic signed [scr_pkg::POS_W-1:0]  out_z,
  output logic                              out_table_full,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [scr_pkg::RAD_W-1:0]         cfg_data
);
  import scr_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ENT  = 4'd1;
  localparam logic [3:0] S_MUL  = 4'd2;
  localparam logic [3:0] S_CMP  = 4'd3;
  localparam logic [3:0] S_SQRT = 4'd4;
  localparam logic [3:0] S_PMUL = 4'd5;
  localparam logic [3:0] S_DIVS = 4'd6;
  localparam logic [3:0] S_DIVW = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  localparam int SQ_IT_W = $clog2(ROOT_W + 1);
  localparam int SUM_W = POS_W + 2;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi, lo;
    hi = SUM_W'((1 << (POS_W - 1)) - 1);
    lo = -SUM_W'(1 << (POS_W - 1));
    if (v > hi) sat_pos = hi[POS_W-1:0];
    else if (v < lo) sat_pos = lo[POS_W-1:0];
    else sat_pos = v[POS_W-1:0];
  endfunction

  logic [3:0] state_r;
  logic [RAD_W-1:0] pr_r;
  logic [GAP_W-1:0] gap_r;
  logic [CNT_W-1:0] cnt_r, idx_r;
  logic signed [POS_W-1:0] cx_r [MAX_SPHERES];
  logic signed [POS_W-1:0] cy_r [MAX_SPHERES];
  logic signed [POS_W-1:0] cz_r [MAX_SPHERES];
  logic [RAD_W-1:0] rad_r [MAX_SPHERES];
  logic info_r [MAX_SPHERES];
  logic signed [POS_W-1:0] p_r [3];
  logic signed [POS_W-1:0] np_r [3];
  logic hit_r, hinfo_r, full_r, pass_r;
  logic [IDX_W-1:0] hidx_r;
  logic [1:0] mstep_r, comp_r;
  logic [PROD_W-1:0] acc_r, msq_r, sq_v_r;
  logic [ROOT_W+1:0] sq_rem_r;
  logic [ROOT_W-1:0] sq_root_r;
  logic [SQ_IT_W-1:0] sq_it_r;
  logic [NUM_W-1:0] num_r;
  logic out_valid_r, o_col_r, o_info_r, o_full_r;
  logic [3:0] o_idx_r;
  logic signed [POS_W-1:0] o_x_r, o_y_r, o_z_r;

  logic [IDX_W-1:0] tidx;
  logic signed [POS_W-1:0] c [3];
  logic [MD_W-1:0] md;
  logic signed [MAG_W-1:0] diff [3];
  logic [MAG_W-1:0] mag [3];
  logic [MAG_W-1:0] ma, mb;
  logic [PROD_W-1:0] prod;
  logic [ROOT_W+1:0] sq_sh, sq_trial;
  logic signed [SUM_W-1:0] qs, csum;
  logic [Q_W-1:0] quot;
  div_ctl_t div_ctl;
  div_sts_t div_sts;

  assign tidx = idx_r[IDX_W-1:0];
  assign c[0] = cx_r[tidx];
  assign c[1] = cy_r[tidx];
  assign c[2] = cz_r[tidx];
  assign md = MD_W'(rad_r[tidx]) + MD_W'(pr_r) + (pass_r ? '0 : MD_W'(gap_r));

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k] = MAG_W'(p_r[k]) - MAG_W'(c[k]);
      mag[k] = diff[k][MAG_W-1] ? MAG_W'(-diff[k]) : MAG_W'(diff[k]);
    end
  end

  always_comb begin
    ma = MAG_W'(md);
    mb = MAG_W'(md);
    if (state_r == S_PMUL) begin
      ma = mag[comp_r];
    end else if (mstep_r != 2'd3) begin
      ma = mag[mstep_r];
      mb = mag[mstep_r];
    end
  end
  assign prod = ma * mb;

  assign sq_sh = {sq_rem_r[ROOT_W-1:0], sq_v_r[PROD_W-1:PROD_W-2]};
  assign sq_trial = {sq_root_r, 2'b01};

  assign qs = diff[comp_r][MAG_W-1] ? -SUM_W'(quot) : SUM_W'(quot);
  assign csum = SUM_W'(c[comp_r]) + qs;

  assign div_ctl.start = (state_r == S_DIVS);

  scr_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (div_ctl),
    .num  (num_r),
    .den  (sq_root_r),
    .sts  (div_sts),
    .quot (quot)
  );

  assign in_ready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pr_r <= PLAYER_RADIUS_RST;
      gap_r <= DETECT_GAP_RST;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_PLAYER_RADIUS: pr_r <= cfg_data;
          CFG_DETECT_GAP: gap_r <= cfg_data[GAP_W-1:0];
          default: ;
        endcase
      end
      if (state_r == S_FIN && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            hit_r <= 1'b0;
            hidx_r <= '0;
            hinfo_r <= 1'b0;
            pass_r <= 1'b0;
            idx_r <= '0;
            if (in_cmd == CMD_ADD) begin
              p_r[0] <= '0;
              p_r[1] <= '0;
              p_r[2] <= '0;
              full_r <= (cnt_r >= CNT_W'(MAX_SPHERES));
              if (cnt_r < CNT_W'(MAX_SPHERES)) begin
                cx_r[cnt_r[IDX_W-1:0]] <= in_pos_x;
                cy_r[cnt_r[IDX_W-1:0]] <= in_pos_y;
                cz_r[cnt_r[IDX_W-1:0]] <= in_pos_z;
                rad_r[cnt_r[IDX_W-1:0]] <= in_sphere_radius;
                info_r[cnt_r[IDX_W-1:0]] <= in_info_present;
                cnt_r <= cnt_r + CNT_W'(1);
              end
              state_r <= S_FIN;
            end else begin
              p_r[0] <= in_pos_x;
              p_r[1] <= in_pos_y;
              p_r[2] <= in_pos_z;
              full_r <= 1'b0;
              state_r <= S_ENT;
            end
          end
        end
        S_ENT: begin
          mstep_r <= 2'd0;
          state_r <= (idx_r == cnt_r) ? S_FIN : S_MUL;
        end
        S_MUL: begin
          mstep_r <= mstep_r + 2'd1;
          if (mstep_r == 2'd0) acc_r <= prod;
          else if (mstep_r == 2'd3) begin
            msq_r <= prod;
            state_r <= S_CMP;
          end else acc_r <= acc_r + prod;
        end
        S_CMP: begin
          if (acc_r < msq_r && !pass_r) begin
            hit_r <= 1'b1;
            hidx_r <= tidx;
            hinfo_r <= info_r[tidx];
            pass_r <= 1'b1;
            idx_r <= '0;
            state_r <= S_ENT;
          end else if (acc_r < msq_r && acc_r != '0) begin
            sq_v_r <= acc_r;
            sq_rem_r <= '0;
            sq_root_r <= '0;
            sq_it_r <= SQ_IT_W'(ROOT_W);
            state_r <= S_SQRT;
          end else begin
            if (acc_r < msq_r) begin
              p_r[0] <= sat_pos(SUM_W'(c[0]) + SUM_W'(md));
              p_r[1] <= c[1];
              p_r[2] <= c[2];
            end
            idx_r <= idx_r + CNT_W'(1);
            state_r <= S_ENT;
          end
        end
        S_SQRT: begin
          sq_v_r <= {sq_v_r[PROD_W-3:0], 2'b00};
          if (sq_sh >= sq_trial) begin
            sq_rem_r <= sq_sh - sq_trial;
            sq_root_r <= {sq_root_r[ROOT_W-2:0], 1'b1};
          end else begin
            sq_rem_r <= sq_sh;
            sq_root_r <= {sq_root_r[ROOT_W-2:0], 1'b0};
          end
          sq_it_r <= sq_it_r - SQ_IT_W'(1);
          comp_r <= 2'd0;
          if (sq_it_r == SQ_IT_W'(1)) state_r <= S_PMUL;
        end
        S_PMUL: begin
          num_r <= NUM_W'(prod) + NUM_W'(sq_root_r >> 1);
          state_r <= S_DIVS;
        end
        S_DIVS: state_r <= S_DIVW;
        S_DIVW: begin
          if (div_sts.done) begin
            np_r[comp_r] <= sat_pos(csum);
            if (comp_r == 2'd2) begin
              p_r[0] <= np_r[0];
              p_r[1] <= np_r[1];
              p_r[2] <= sat_pos(csum);
              idx_r <= idx_r + CNT_W'(1);
              state_r <= S_ENT;
            end else begin
              comp_r <= comp_r + 2'd1;
              state_r <= S_PMUL;
            end
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_ready) begin
            o_col_r <= hit_r;
            o_idx_r <= 4'(hidx_r);
            o_info_r <= hinfo_r;
            o_x_r <= p_r[0];
            o_y_r <= p_r[1];
            o_z_r <= p_r[2];
            o_full_r <= full_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_collided = o_col_r;
  assign out_hit_index = o_idx_r;
  assign out_hit_info = o_info_r;
  assign out_x = o_x_r;
  assign out_y = o_y_r;
  assign out_z = o_z_r;
  assign out_table_full = o_full_r;

endmodule

FILE: src/scr_chk.sv
// Port-level checker for the sphere collision resolver, bound to the top level.
module scr_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             out_collided,
  input logic [3:0]                       out_hit_index,
  input logic                             out_hit_info,
  input logic signed [scr_pkg::POS_W-1:0] out_x,
  input logic                             out_table_full
);
  import scr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_collided))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while busy");

  a_full_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_table_full |-> !out_collided && out_x == '0)
    else $error("dropped add reported a hit or a point");

  a_miss_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_collided |-> out_hit_index == 4'd0 && !out_hit_info)
    else $error("miss reported hit details");

endmodule

bind sphere_collision_resolve_core scr_chk u_scr_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_collided  (out_collided),
  .out_hit_index (out_hit_index),
  .out_hit_info  (out_hit_info),
  .out_x         (out_x),
  .out_table_full(out_table_full)
);
